FILE: rtl/config_key_value_response_parser_assert.svh
// Assertion macros used by the checker file.
`ifndef CONFIG_KEY_VALUE_RESPONSE_PARSER_ASSERT_SVH
`define CONFIG_KEY_VALUE_RESPONSE_PARSER_ASSERT_SVH

// Check that a condition implies another at the same edge.
`define CKVRP_ASSERT_IMPLY(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define CKVRP_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/ckvrp_pkg.sv
package ckvrp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int SIZE_W    = 4;
    localparam int M_USED_W  = KEY_W + VAL_W + SIZE_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;
    localparam int M_TUSER_W = 2;

    // One result request, as it travels from the parser to the output stage.
    typedef struct packed {
        logic              pair_valid;
        logic [KEY_W-1:0]  key_id;
        logic [VAL_W-1:0]  key_value;
        logic [SIZE_W-1:0] value_bytes;
        logic              frame_done;
        logic              frame_ok;
    } ckvrp_result_t;

endpackage

FILE: rtl/config_key_value_response_parser.sv
// Configuration read response parser.
// Input stream (s_*): one payload byte per request, s_tlast on the final
// byte. The first four bytes of a payload are header and are skipped; then
// key/value pairs follow: a little-endian 32-bit key, then a little-endian
// value of 1, 2, 4 or 8 bytes chosen by the key's top nibble (only the low
// 32 bits of a value are kept).
// Output stream (m_*): one request per complete pair and one on the final
// byte (both in one request when a pair ends on the final byte). m_tlast
// marks frame done; m_tuser[1] says the frame held a full header.
// Throughput: one byte per cycle while s_tready is high; the parser state
// updates on every accepted byte. A result is written to the queue at the
// edge that accepts the byte that causes it, and is then loaded from the
// queue into the output register, which drives m_tvalid.
// Reset: parser returns to the header phase; queue and output are empty.
// Stall: while m_tready is low the output register holds its request and
// the queue of QUEUE_DEPTH entries fills; s_tready drops only when it is full.
module config_key_value_response_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [7:0] data_byte
    input  logic [ckvrp_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [31:0] key_id, [63:32] key_value, [67:64] value_bytes, rest zero
    output logic [ckvrp_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: [0] pair_valid, [1] frame_ok
    output logic [ckvrp_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready
);

    logic                     s_accept;
    logic                     push_valid, push_ready;
    ckvrp_pkg::ckvrp_result_t push_data;
    logic                     pop_valid, pop_ready;
    ckvrp_pkg::ckvrp_result_t pop_data;
    ckvrp_pkg::ckvrp_result_t out_data;

    // Take a byte only when the queue has room for whatever it may produce.
    assign s_tready = push_ready;
    assign s_accept = s_tvalid && push_ready;

    // Front: track header / key / value phase and form result requests.
    ckvrp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (s_accept),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // Queue between parser and output so each side can stall on its own.
    ckvrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: registered output stage driving the master stream.
    ckvrp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result fields onto the stream ports.
    assign m_tdata = {{ckvrp_pkg::M_PAD_W{1'b0}}, out_data.value_bytes,
                      out_data.key_value, out_data.key_id};
    assign m_tuser = {out_data.frame_ok, out_data.pair_valid};
    assign m_tlast = out_data.frame_done;

endmodule

FILE: rtl/ckvrp_front.sv
module ckvrp_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_accept,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             push_valid,
    output ckvrp_pkg::ckvrp_result_t         push_data
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_KEY    = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [3:0] HDR_BYTES = 4'd4;
    localparam logic [3:0] KEY_BYTES = 4'd4;

    function automatic logic [3:0] size_of_key(input logic [31:0] key);
        logic [3:0] sz;
        case (key[31:28])
            4'd3:    sz = 4'd2;
            4'd4:    sz = 4'd4;
            4'd5:    sz = 4'd8;
            default: sz = 4'd1;
        endcase
        return sz;
    endfunction

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] accum_reg, accum_next;
    logic [3:0]  size_reg, size_next;

    logic [3:0]  count_inc;
    logic [4:0]  shift_amt;
    logic [31:0] byte_shifted;
    logic        ok;
    logic        pair;

    assign count_inc    = count_reg + 4'd1;
    assign shift_amt    = {count_reg[1:0], 3'b000};
    assign byte_shifted = 32'(data_byte) << shift_amt;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_inc;
        key_next   = key_reg;
        accum_next = accum_reg;
        size_next  = size_reg;
        ok         = 1'b0;
        pair       = 1'b0;

        case (phase_reg)
            PH_KEY: begin
                ok = 1'b1;
                if (count_reg < KEY_BYTES) begin
                    key_next = key_reg | byte_shifted;
                end
                if (count_inc >= KEY_BYTES) begin
                    size_next  = size_of_key(key_next);
                    accum_next = '0;
                    phase_next = PH_VALUE;
                    count_next = '0;
                end
            end
            PH_VALUE: begin
                ok = 1'b1;
                // bytes past the fourth are consumed but dropped
                if (count_reg < 4'd4) begin
                    accum_next = accum_reg | byte_shifted;
                end
                pair = count_inc >= size_reg;
            end
            default: begin
                ok = count_inc >= HDR_BYTES;
                if (ok) begin
                    phase_next = PH_KEY;
                    key_next   = '0;
                    count_next = '0;
                end else begin
                    phase_next = PH_HEADER;
                end
            end
        endcase

        push_data.pair_valid  = pair;
        push_data.key_id      = pair ? key_reg : '0;
        push_data.key_value   = pair ? accum_next : '0;
        push_data.value_bytes = pair ? size_reg : '0;
        push_data.frame_done  = last_byte;
        push_data.frame_ok    = last_byte && ok;

        if (pair) begin
            phase_next = PH_KEY;
            count_next = '0;
            key_next   = '0;
            accum_next = '0;
        end
        if (last_byte) begin
            phase_next = PH_HEADER;
            count_next = '0;
            key_next   = '0;
            accum_next = '0;
            size_next  = 4'd1;
        end
    end

    assign push_valid = in_accept && (pair || last_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            key_reg   <= '0;
            accum_reg <= '0;
            size_reg  <= 4'd1;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            key_reg   <= key_next;
            accum_reg <= accum_next;
            size_reg  <= size_next;
        end
    end

endmodule

FILE: rtl/ckvrp_queue.sv
module ckvrp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push_valid,
    output logic                             push_ready,
    input  ckvrp_pkg::ckvrp_result_t         push_data,
    output logic                             pop_valid,
    input  logic                             pop_ready,
    output ckvrp_pkg::ckvrp_result_t         pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ckvrp_pkg::ckvrp_result_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/ckvrp_back.sv
module ckvrp_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  ckvrp_pkg::ckvrp_result_t         pop_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ckvrp_pkg::ckvrp_result_t         out_data
);

    logic                     valid_reg;
    ckvrp_pkg::ckvrp_result_t data_reg;

    // refill whenever the output slot is empty or being drained
    assign pop_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            data_reg <= pop_data;
        end
    end

endmodule

FILE: rtl/ckvrp_checker.sv
`include "config_key_value_response_parser_assert.svh"

module ckvrp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic [ckvrp_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [ckvrp_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                              m_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    `CKVRP_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "stalled result dropped")
    `CKVRP_ASSERT_NEXT(a_m_data_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `CKVRP_ASSERT_IMPLY(a_no_pair_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "non-pair result carries data")
    `CKVRP_ASSERT_IMPLY(a_ok_needs_done, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast, "frame ok without frame done")
    `CKVRP_ASSERT_IMPLY(a_pair_size, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[67:64] == 4'd1 || m_tdata[67:64] == 4'd2 || m_tdata[67:64] == 4'd4 || m_tdata[67:64] == 4'd8, "bad value size on pair")

endmodule

bind config_key_value_response_parser ckvrp_checker u_ckvrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
